>>> src/odbp_pkg.sv
// Shared types, constants and the Bayer threshold table for the ordered
// dither bit packer. No dependencies; every other source file imports it.
`default_nettype none

package odbp_pkg;

    // Field and counter widths fixed by the pixel and result formats.
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned SIZE_W   = 14;
    localparam int unsigned CFG_IDX_W = 8;

    // Default limits for the row and page size parameters.
    localparam int unsigned MAX_ROW_PIXELS_DEF = 10000;
    localparam int unsigned MAX_PAGE_ROWS_DEF  = 15000;

    // Register reset values.
    localparam logic [SIZE_W-1:0] LINE_WIDTH_RST = 14'd4760;
    localparam logic [SIZE_W-1:0] PAGE_ROWS_RST  = 14'd6818;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_ROWS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RGB_INPUT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_DOTS = 8'd3;

    // Luma weights, in units of 1/256.
    localparam logic [15:0] GRAY_R_WEIGHT = 16'd77;
    localparam logic [15:0] GRAY_G_WEIGHT = 16'd150;
    localparam logic [15:0] GRAY_B_WEIGHT = 16'd29;

    // One input item: a gray sample or an RGB triple.
    typedef struct packed {
        logic [SAMPLE_W-1:0] red_or_gray;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } pixel_t;

    // One result item: eight packed dots and the line and page marks.
    typedef struct packed {
        logic [7:0] packed_byte;
        logic       end_of_row;
        logic       end_of_page;
    } result_t;

    // Effective configuration, with sizes already limited to a legal range.
    typedef struct packed {
        logic [SIZE_W-1:0] line_width;
        logic [SIZE_W-1:0] page_rows;
        logic              rgb_input;
        logic              invert_dots;
    } cfg_t;

    // Low bits of the row and column counters, which pick the threshold.
    typedef struct packed {
        logic [2:0] row_phase;
        logic [2:0] col_phase;
    } phase_t;

    // 8x8 Bayer threshold matrix, indexed by row phase then column phase.
    localparam logic [7:0] BAYER_TAB [8][8] = '{
        '{8'd0,   8'd128, 8'd32,  8'd160, 8'd8,   8'd136, 8'd40,  8'd168},
        '{8'd192, 8'd64,  8'd224, 8'd96,  8'd200, 8'd72,  8'd232, 8'd104},
        '{8'd48,  8'd176, 8'd16,  8'd144, 8'd56,  8'd184, 8'd24,  8'd152},
        '{8'd240, 8'd112, 8'd208, 8'd80,  8'd248, 8'd120, 8'd216, 8'd88},
        '{8'd12,  8'd140, 8'd44,  8'd172, 8'd4,   8'd132, 8'd36,  8'd164},
        '{8'd204, 8'd76,  8'd236, 8'd108, 8'd196, 8'd68,  8'd228, 8'd100},
        '{8'd60,  8'd188, 8'd28,  8'd156, 8'd52,  8'd180, 8'd20,  8'd148},
        '{8'd252, 8'd124, 8'd220, 8'd92,  8'd244, 8'd116, 8'd212, 8'd84}
    };

    function automatic logic [7:0] bayer_threshold(input phase_t ph);
        return BAYER_TAB[ph.row_phase][ph.col_phase];
    endfunction

endpackage

`default_nettype wire

>>> src/ordered_dither_bit_packer.sv
// Top level of the ordered dither bit packer: input register, dither
// decision, packer and configuration registers. Depends on odbp_pkg and
// odbp_cfg_regs, odbp_dither, odbp_packer.
//
// Usage: pixels enter on px with px_valid/px_ready, one item per pixel in
// raster order. Packed bytes leave on res with res_valid/res_ready: one
// result after every eighth pixel of a row and one at the end of each row,
// flagged with end_of_row, and end_of_page on the last row of a page.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while
// the block is idle: 0 line width, 1 page rows, 2 RGB input, 3 inverted dots.
// A pixel that closes a result is loaded into the input register and then,
// once the result register can take a byte, into the result register.
// Throughput is one pixel per cycle while the receiver takes results, set
// by the single pass from the input register through the gray sum and
// threshold compare into the packer state.
// Reset clears the counters and the bit accumulator and loads the default
// sizes; no clearing pass is needed. When the receiver stalls, the result
// register holds its byte; one more pixel can wait in the input register,
// and px_ready drops while that pixel waits and the result is still held.
`default_nettype none

module ordered_dither_bit_packer
    import odbp_pkg::*;
#(
    parameter int unsigned MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF,
    parameter int unsigned MAX_PAGE_ROWS  = MAX_PAGE_ROWS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 px_valid,
    output logic                      px_ready,
    input  wire pixel_t               px,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output result_t                   res,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_wdata
);

    cfg_t   cfg;
    phase_t phase;
    pixel_t px_reg;
    logic   px_valid_reg, px_valid_next;
    logic   advance;
    logic   black;

    // The held pixel moves on whenever the result register can take a byte.
    assign advance  = px_valid_reg && (!res_valid || res_ready);
    assign px_ready = !px_valid_reg || advance;

    always_comb
    begin
        px_valid_next = px_valid_reg;
        if (px_valid && px_ready)
            px_valid_next = 1'b1;
        else if (advance)
            px_valid_next = 1'b0;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            px_valid_reg <= 1'b0;
        else
            px_valid_reg <= px_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (px_valid && px_ready)
            px_reg <= px;
    end

    odbp_cfg_regs #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
        .MAX_PAGE_ROWS  (MAX_PAGE_ROWS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    odbp_dither u_dither (
        .px    (px_reg),
        .cfg   (cfg),
        .phase (phase),
        .black (black)
    );

    odbp_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .black     (black),
        .cfg       (cfg),
        .res_ready (res_ready),
        .phase     (phase),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

`default_nettype wire

>>> src/odbp_cfg_regs.sv
// Configuration registers of the ordered dither bit packer, with limiting
// of the row and page sizes. Depends on odbp_pkg.
`default_nettype none

module odbp_cfg_regs
    import odbp_pkg::*;
#(
    parameter int unsigned MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF,
    parameter int unsigned MAX_PAGE_ROWS  = MAX_PAGE_ROWS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_wdata,
    output cfg_t                      cfg
);

    localparam logic [SIZE_W-1:0] MAX_W = SIZE_W'(MAX_ROW_PIXELS);
    localparam logic [SIZE_W-1:0] MAX_H = SIZE_W'(MAX_PAGE_ROWS);

    logic [SIZE_W-1:0] line_width_reg;
    logic [SIZE_W-1:0] page_rows_reg;
    logic              rgb_input_reg;
    logic              invert_dots_reg;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= LINE_WIDTH_RST;
            page_rows_reg   <= PAGE_ROWS_RST;
            rgb_input_reg   <= 1'b0;
            invert_dots_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINE_WIDTH:  line_width_reg  <= cfg_wdata;
                CFG_PAGE_ROWS:   page_rows_reg   <= cfg_wdata;
                CFG_RGB_INPUT:   rgb_input_reg   <= cfg_wdata[0];
                CFG_INVERT_DOTS: invert_dots_reg <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // A size of zero acts as one, and sizes above the limit saturate.
    always_comb
    begin
        cfg.line_width = line_width_reg;
        if (line_width_reg == '0)
            cfg.line_width = SIZE_W'(1);
        else if (line_width_reg > MAX_W)
            cfg.line_width = MAX_W;

        cfg.page_rows = page_rows_reg;
        if (page_rows_reg == '0)
            cfg.page_rows = SIZE_W'(1);
        else if (page_rows_reg > MAX_H)
            cfg.page_rows = MAX_H;

        cfg.rgb_input   = rgb_input_reg;
        cfg.invert_dots = invert_dots_reg;
    end

endmodule

`default_nettype wire

>>> src/odbp_dither.sv
// Gray conversion and ordered dither decision for one pixel.
// Depends on odbp_pkg for the pixel type, weights and Bayer table.
`default_nettype none

module odbp_dither
    import odbp_pkg::*;
(
    input  wire pixel_t px,
    input  wire cfg_t   cfg,
    input  wire phase_t phase,
    output logic        black
);

    logic [15:0]         luma_sum;
    logic [SAMPLE_W-1:0] gray;
    logic [7:0]          thresh;

    // Weighted sum of the components; the top byte is the gray value.
    assign luma_sum = 16'(px.red_or_gray) * GRAY_R_WEIGHT
                    + 16'(px.green) * GRAY_G_WEIGHT
                    + 16'(px.blue) * GRAY_B_WEIGHT;

    assign gray   = cfg.rgb_input ? luma_sum[15:8] : px.red_or_gray;
    assign thresh = bayer_threshold(phase);

    // Normal mode prints dark pixels; inverted mode prints light ones.
    assign black = cfg.invert_dots ? (gray > thresh) : (~gray > thresh);

endmodule

`default_nettype wire

>>> src/odbp_packer.sv
// Row and column counters, dot accumulator and result register of the
// ordered dither bit packer. Depends on odbp_pkg.
`default_nettype none

module odbp_packer
    import odbp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  wire logic black,
    input  wire cfg_t cfg,
    input  wire logic res_ready,
    output phase_t    phase,
    output logic      res_valid,
    output result_t   res
);

    logic [SIZE_W-1:0] col_reg, col_next;
    logic [SIZE_W-1:0] row_reg, row_next;
    logic [7:0]        acc_reg, acc_next;
    logic [2:0]        pos_reg, pos_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;

    logic [7:0] acc_with_dot;
    logic       row_end;
    logic       page_end;
    logic       emit;

    assign phase.row_phase = row_reg[2:0];
    assign phase.col_phase = col_reg[2:0];

    // Position tests and the accumulator with the current dot set.
    assign acc_with_dot = acc_reg | (8'(black) << pos_reg);
    assign row_end  = ({1'b0, col_reg} + 15'd1) >= {1'b0, cfg.line_width};
    assign page_end = row_end && (({1'b0, row_reg} + 15'd1) >= {1'b0, cfg.page_rows});
    assign emit     = row_end || (pos_reg == 3'd0);

    // Next state for one pixel moving through, and for the result handshake.
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;

        if (advance)
        begin
            if (emit)
            begin
                res_next.packed_byte = acc_with_dot;
                res_next.end_of_row  = row_end;
                res_next.end_of_page = page_end;
                res_valid_next       = 1'b1;
                acc_next             = '0;
                pos_next             = 3'd7;
            end
            else
            begin
                acc_next = acc_with_dot;
                pos_next = pos_reg - 3'd1;
            end

            if (row_end)
            begin
                col_next = '0;
                row_next = page_end ? '0 : row_reg + SIZE_W'(1);
            end
            else
            begin
                col_next = col_reg + SIZE_W'(1);
            end
        end
    end

    // Control and counter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            acc_reg       <= '0;
            pos_reg       <= 3'd7;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

>>> src/odbp_checker.sv
// Port-level checks for the ordered dither bit packer and the bind that
// attaches them to the top level. Depends on odbp_pkg.
`default_nettype none

module odbp_port_checks
    import odbp_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 px_valid,
    input wire logic                 px_ready,
    input wire pixel_t               px,
    input wire logic                 res_valid,
    input wire logic                 res_ready,
    input wire result_t              res,
    input wire logic                 cfg_we,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [SIZE_W-1:0]    cfg_wdata
);

    // A stalled result keeps its byte and flags.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // The last byte of a page is always the last byte of a row.
    a_page_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.end_of_page |-> res.end_of_row)
        else $error("end_of_page without end_of_row");

    // A receiver that takes results never holds back the pixel stream.
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> px_ready)
        else $error("pixel input stalled while results are taken");

    // Right after reset no result is shown and a pixel can be taken.
    a_reset_state: assert property (@(posedge clk)
        !$past(rst_n) |-> !res_valid && px_ready)
        else $error("block not empty after reset");

endmodule

bind ordered_dither_bit_packer odbp_port_checks u_odbp_port_checks (.*);

`default_nettype wire
